FILE: sv/tpd_pkg.sv
// shared types and constants for the trapezoid profile drive
`default_nettype none
package tpd_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned DutyW = 16;
  localparam int unsigned TickRate = 1024;
  localparam int unsigned TickSh = $clog2(TickRate);
  localparam logic signed [31:0] BaseDuty = 32'sd9830;
  localparam logic signed [31:0] OneQ = 32'sd65536;
  localparam logic [31:0] LinTol = 32'd65536;
  localparam logic [31:0] AngTol = 32'd3277;
  localparam logic [1:0] KindIdle = 2'd0;
  localparam logic [1:0] KindStraight = 2'd1;
  localparam logic [1:0] KindRotate = 2'd2;
  localparam logic [1:0] KindReserved = 2'd3;
  localparam logic [2:0] RegDistGain = 3'd0;
  localparam logic [2:0] RegHeadGain = 3'd1;
  localparam logic [2:0] RegGoalDist = 3'd2;
  localparam logic [2:0] RegGoalHead = 3'd3;
  localparam logic [2:0] RegBrakeDist = 3'd4;
  localparam logic [2:0] RegBrakeAng = 3'd5;
  localparam logic [2:0] RegStartAcc = 3'd6;
  localparam logic [2:0] RegStartTurn = 3'd7;

  typedef struct packed {
    logic        start_req;
    logic [1:0]  move_kind;
    logic signed [31:0] measured_distance;
    logic signed [31:0] measured_heading;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] left_duty;
    logic [15:0] right_duty;
  } out_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

FILE: sv/tpd_if.sv
// valid/ready channel interfaces
`default_nettype none
interface tpd_in_if;
  logic valid;
  logic ready;
  tpd_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpd_out_if;
  logic valid;
  logic ready;
  tpd_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/tpd_divider.sv
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module tpd_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] sh;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[32:0], quo_q[63]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[62:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = sh;
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule
`default_nettype wire

FILE: sv/trapezoid_profile_p_drive_core.sv
// trapezoid profile drive core: proportional duty and setpoint integration
// usage: one input beat per control tick on in_if; one duty beat leaves on
// out_if for each accepted tick. configuration goes through the apb port
// (byte address 4*index); the user must write it only while the core is
// idle, the core does not enforce this. the shared multiplier steps
// through four products, then squares the speed for the axis check, and
// the setpoint update runs; the duty beat is then loaded into the output
// register before the core returns to idle. when braking starts, the
// 64-step brake divider runs between the axis check and setpoint update.
// in_if.ready is high only while the sequencer is idle.
// a stalled out_if keeps the duty beat held in the output register; the next
// tick is still computed and then waits for that register, so in_if stays
// low until the receiver takes the held beat.
// reset clears all setpoints and accelerations and loads register defaults.
`default_nettype none
module trapezoid_profile_p_drive_core #(
  parameter int unsigned MAX_LINEAR_SPEED = 65536,
  parameter int unsigned MAX_TURN_SPEED = 65536,
  parameter int unsigned PWM_PERIOD = 4095
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tpd_in_if.sink           in_if,
  tpd_out_if.source        out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StMulD  = 9'b000000010,
    StMulH  = 9'b000000100,
    StMulL  = 9'b000001000,
    StMulR  = 9'b000010000,
    StCheck = 9'b000100000,
    StDiv   = 9'b001000000,
    StInteg = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic signed [31:0] kd_q, kh_q, gd_q, gh_q, sa_q, st_q;
  logic [30:0] bd_q, ba_q;
  logic signed [31:0] pos_q, hdg_q, lv_q, tv_q, la_q, ta_q;
  logic signed [31:0] pos_d, hdg_d, lv_d, tv_d, la_d, ta_d;
  logic [1:0] kind_q;
  logic signed [31:0] ed_q, eh_q;
  logic signed [47:0] pd_q, ph_q;
  logic [15:0] ld_q, rd_q;
  logic rot_q;
  logic ov_q, ld_out;
  logic [15:0] lo_q, ro_q;

  // shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  logic        wr;
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kd_q <= '0; kh_q <= '0; gd_q <= '0; gh_q <= '0; sa_q <= '0; st_q <= '0;
      bd_q <= 31'd65536; ba_q <= 31'd65536;
    end else if (wr) begin
      case (paddr[4:2])
        tpd_pkg::RegDistGain: kd_q <= pwdata;
        tpd_pkg::RegHeadGain: kh_q <= pwdata;
        tpd_pkg::RegGoalDist: gd_q <= pwdata;
        tpd_pkg::RegGoalHead: gh_q <= pwdata;
        tpd_pkg::RegBrakeDist: bd_q <= pwdata[30:0];
        tpd_pkg::RegBrakeAng: ba_q <= pwdata[30:0];
        tpd_pkg::RegStartAcc: sa_q <= pwdata;
        tpd_pkg::RegStartTurn: st_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tpd_pkg::RegDistGain: prdata = kd_q;
      tpd_pkg::RegHeadGain: prdata = kh_q;
      tpd_pkg::RegGoalDist: prdata = gd_q;
      tpd_pkg::RegGoalHead: prdata = gh_q;
      tpd_pkg::RegBrakeDist: prdata = {1'b0, bd_q};
      tpd_pkg::RegBrakeAng: prdata = {1'b0, ba_q};
      tpd_pkg::RegStartAcc: prdata = sa_q;
      tpd_pkg::RegStartTurn: prdata = st_q;
      default: prdata = '0;
    endcase
  end

  // axis check signals
  logic signed [31:0] goal, setp, spd, acc;
  logic [30:0] span0;
  logic [31:0] span, tol;
  logic signed [34:0] left, rem, labs, rabs;
  logic gsgn_p, gsgn_n, brake;
  always_comb begin
    goal = rot_q ? gh_q : gd_q;
    setp = rot_q ? hdg_q : pos_q;
    spd = rot_q ? tv_q : lv_q;
    acc = rot_q ? ta_q : la_q;
    span0 = rot_q ? ba_q : bd_q;
    span = (span0 == '0) ? 32'd1 : {1'b0, span0};
    tol = rot_q ? tpd_pkg::AngTol : tpd_pkg::LinTol;
    gsgn_p = goal > 0;
    gsgn_n = goal < 0;
    left = 35'(goal) - 35'(setp);
    rem = (gsgn_p ? left : gsgn_n ? -left : 35'sd0) - $signed({3'b0, span});
    labs = left < 0 ? -left : left;
    rabs = rem < 0 ? -rem : rem;
    brake = rabs < $signed({3'b0, tol});
  end

  logic [31:0] vmag;
  assign vmag = spd < 0 ? 32'(-33'(spd)) : 32'(spd);
  logic dv_start, dv_done;
  logic [63:0] dv_q;
  tpd_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dv_start),
    .num_i(mp[63:0]), .den_i({span, 1'b0}),
    .done_o(dv_done), .quo_o(dv_q)
  );

  logic [31:0] bmag;
  assign bmag = (dv_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q[31:0];

  function automatic logic [15:0] duty(input logic signed [65:0] p);
    logic signed [33:0] q;
    q = (p < 0) ? 34'sd0 : (p > 66'sd65536 * $signed(67'(PWM_PERIOD)) ? 34'(PWM_PERIOD) << 16
        : p[33:0]);
    return q[31:16];
  endfunction

  function automatic logic signed [31:0] tdiv(input logic signed [31:0] v);
    logic signed [31:0] s;
    s = v >>> tpd_pkg::TickSh;
    if (v < 0 && (v & 32'((tpd_pkg::TickRate) - 1)) != 0) s = s + 32'sd1;
    return s;
  endfunction

  logic signed [49:0] lq, rq;
  assign lq = 50'(tpd_pkg::BaseDuty) + 50'(pd_q) - 50'(ph_q);
  assign rq = 50'(tpd_pkg::BaseDuty) - 50'(pd_q) - 50'(ph_q);

  logic signed [31:0] lcl, rcl;
  assign lcl = lq < 0 ? 32'sd0 : (lq > 50'sd65536 ? tpd_pkg::OneQ : 32'(lq));
  assign rcl = rq < 0 ? 32'sd0 : (rq > 50'sd65536 ? tpd_pkg::OneQ : 32'(rq));

  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      StMulD: begin ma = 33'(kd_q); mb = 33'(ed_q); end
      StMulH: begin ma = 33'(kh_q); mb = 33'(eh_q); end
      StMulL: begin ma = 33'(lcl); mb = 33'(PWM_PERIOD); end
      StMulR: begin ma = 33'(rcl); mb = 33'(PWM_PERIOD); end
      StCheck: begin ma = 33'(vmag); mb = 33'(vmag); end
      default: ;
    endcase
  end

  assign ld_out = (state_q == StOut) && (!ov_q || out_if.ready);

  logic signed [31:0] nacc;
  always_comb begin
    state_d = state_q;
    pos_d = pos_q; hdg_d = hdg_q; lv_d = lv_q; tv_d = tv_q; la_d = la_q; ta_d = ta_q;
    dv_start = 1'b0;
    nacc = acc;
    case (state_q)
      StIdle: if (in_if.valid) state_d = StMulD;
      StMulD: state_d = StMulH;
      StMulH: state_d = StMulL;
      StMulL: state_d = StMulR;
      StMulR: state_d = StCheck;
      StCheck: begin
        state_d = StInteg;
        if (kind_q == tpd_pkg::KindStraight || kind_q == tpd_pkg::KindRotate) begin
          if (brake) begin
            dv_start = 1'b1; state_d = StDiv;
          end else if (labs < $signed({3'b0, tol})) begin
            if (rot_q) begin tv_d = '0; ta_d = '0; end
            else begin lv_d = '0; la_d = '0; end
          end
        end
      end
      StDiv: if (dv_done) begin
        state_d = StInteg;
        nacc = gsgn_p ? -$signed(bmag) : gsgn_n ? $signed(bmag) : 32'sd0;
        if (rot_q) ta_d = nacc; else la_d = nacc;
      end
      StInteg: begin
        state_d = StOut;
        pos_d = tpd_pkg::sat32(65'(pos_q) + 65'(tdiv(lv_q)));
        hdg_d = tpd_pkg::sat32(65'(hdg_q) + 65'(tdiv(tv_q)));
        lv_d = tpd_pkg::sat32(65'(lv_q) + 65'(tdiv(la_q)));
        tv_d = tpd_pkg::sat32(65'(tv_q) + 65'(tdiv(ta_q)));
        if ((lv_d < 0 ? -65'(lv_d) : 65'(lv_d)) > 65'(MAX_LINEAR_SPEED)
            && ((la_q > 0) == (gd_q > 0)) && ((la_q < 0) == (gd_q < 0)))
          la_d = '0;
        if ((tv_d < 0 ? -65'(tv_d) : 65'(tv_d)) > 65'(MAX_TURN_SPEED)
            && ((ta_q > 0) == (gh_q > 0)) && ((ta_q < 0) == (gh_q < 0)))
          ta_d = '0;
      end
      StOut: if (ld_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StIdle && in_if.valid && in_if.data.start_req) begin
      pos_d = '0; hdg_d = '0; lv_d = '0; tv_d = '0; la_d = sa_q; ta_d = st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q <= '0; hdg_q <= '0; lv_q <= '0; tv_q <= '0; la_q <= '0; ta_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; hdg_q <= hdg_d; lv_q <= lv_d; tv_q <= tv_d;
      la_q <= la_d; ta_q <= ta_d;
    end
  end

  logic signed [31:0] pss, hss;
  assign pss = in_if.data.start_req ? 32'sd0 : pos_q;
  assign hss = in_if.data.start_req ? 32'sd0 : hdg_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        kind_q <= in_if.data.move_kind;
        rot_q <= in_if.data.move_kind == tpd_pkg::KindRotate;
        ed_q <= tpd_pkg::sat32(65'(pss) - 65'(in_if.data.measured_distance));
        eh_q <= tpd_pkg::sat32(65'(hss) - 65'(in_if.data.measured_heading));
      end
      StMulD: pd_q <= mp[63:16];
      StMulH: ph_q <= mp[63:16];
      StMulL: ld_q <= duty(mp);
      StMulR: rd_q <= duty(mp);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; lo_q <= '0; ro_q <= '0;
    end else if (ld_out) begin
      ov_q <= 1'b1; lo_q <= ld_q; ro_q <= rd_q;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  assign in_if.ready = state_q == StIdle;
  assign out_if.valid = ov_q;
  assign out_if.data.left_duty = lo_q;
  assign out_if.data.right_duty = ro_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(lo_q) && $stable(ro_q))
    else $error("duty beat dropped");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_start |=> state_q == StDiv) else $error("divider start outside check");
endmodule
`default_nettype wire
